>>> src/rdcb_pkg.sv
// Shared types, widths and register map of the rotating display color band generator.
`default_nettype none

package rdcb_pkg;

  // Pixel counter width
  localparam int COUNT_BITS = 16;

  // Register field widths
  localparam int PPR_W    = 13;
  localparam int LEVEL_W  = 8;
  localparam int DIVIDE_W = 4;
  localparam int STEP_W   = 8;

  // Color offsets, tenths of a pixel
  localparam int OFF_W    = 16;

  // Period in tenths of a pixel: 10 * (2^PPR_W - 1) fits here
  localparam int PERIOD_W = $clog2(((1 << PPR_W) - 1) * 10 + 1);
  // Band compares need one bit more (2*pos and 9*P)
  localparam int BAND_W   = PERIOD_W + 1;

  // Dividend 10*counter + offset, at its largest value
  localparam int DIV_W    = $clog2(((1 << COUNT_BITS) - 1) * 10 + (1 << OFF_W));
  localparam int CNT_W    = $clog2(DIV_W);

  // APB port
  localparam int APB_DATA_W = 32;
  localparam int NUM_REGS   = 6;
  localparam int ADDR_W     = $clog2(NUM_REGS) + 2;
  localparam int IDX_W      = ADDR_W - 2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_PIXELS_PER_REV = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_ON_LEVEL       = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_TACH_DIVIDE    = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_RED_STEP       = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_GREEN_STEP     = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_BLUE_STEP      = IDX_W'(5);

  // Register reset values
  localparam logic [PPR_W-1:0]    RST_PIXELS_PER_REV = PPR_W'(1024);
  localparam logic [LEVEL_W-1:0]  RST_ON_LEVEL       = LEVEL_W'(200);
  localparam logic [DIVIDE_W-1:0] RST_TACH_DIVIDE    = DIVIDE_W'(6);
  localparam logic [STEP_W-1:0]   RST_RED_STEP       = STEP_W'(10);
  localparam logic [STEP_W-1:0]   RST_GREEN_STEP     = STEP_W'(6);
  localparam logic [STEP_W-1:0]   RST_BLUE_STEP      = STEP_W'(42);

  // Input kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_TACH  = 1'b1;

  // Register file contents
  typedef struct packed {
    logic [PPR_W-1:0]    pixels_per_rev;
    logic [LEVEL_W-1:0]  on_level;
    logic [DIVIDE_W-1:0] tach_divide;
    logic [STEP_W-1:0]   red_step;
    logic [STEP_W-1:0]   green_step;
    logic [STEP_W-1:0]   blue_step;
  } cfg_t;

  // Control of the serial remainder units
  typedef struct packed {
    logic load;
    logic shift;
  } mod_ctl_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } rdcb_state_t;

endpackage

`default_nettype wire

>>> src/rdcb_cfg.sv
// APB register file holding the band generator configuration.
`default_nettype none

module rdcb_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [rdcb_pkg::ADDR_W-1:0]      cfg_paddr,
  input  wire logic [rdcb_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic      [rdcb_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                                  cfg_pready,
  output rdcb_pkg::cfg_t                        cfg
);
  import rdcb_pkg::*;

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  // Write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_PIXELS_PER_REV: cfg_nxt.pixels_per_rev = cfg_pwdata[PPR_W-1:0];
        REG_ON_LEVEL:       cfg_nxt.on_level       = cfg_pwdata[LEVEL_W-1:0];
        REG_TACH_DIVIDE:    cfg_nxt.tach_divide    = cfg_pwdata[DIVIDE_W-1:0];
        REG_RED_STEP:       cfg_nxt.red_step       = cfg_pwdata[STEP_W-1:0];
        REG_GREEN_STEP:     cfg_nxt.green_step     = cfg_pwdata[STEP_W-1:0];
        REG_BLUE_STEP:      cfg_nxt.blue_step      = cfg_pwdata[STEP_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixels_per_rev <= RST_PIXELS_PER_REV;
      cfg_r.on_level       <= RST_ON_LEVEL;
      cfg_r.tach_divide    <= RST_TACH_DIVIDE;
      cfg_r.red_step       <= RST_RED_STEP;
      cfg_r.green_step     <= RST_GREEN_STEP;
      cfg_r.blue_step      <= RST_BLUE_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_PIXELS_PER_REV: cfg_prdata = APB_DATA_W'(cfg_r.pixels_per_rev);
      REG_ON_LEVEL:       cfg_prdata = APB_DATA_W'(cfg_r.on_level);
      REG_TACH_DIVIDE:    cfg_prdata = APB_DATA_W'(cfg_r.tach_divide);
      REG_RED_STEP:       cfg_prdata = APB_DATA_W'(cfg_r.red_step);
      REG_GREEN_STEP:     cfg_prdata = APB_DATA_W'(cfg_r.green_step);
      REG_BLUE_STEP:      cfg_prdata = APB_DATA_W'(cfg_r.blue_step);
      default:            cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/rdcb_mod.sv
// Bit-serial restoring remainder: one dividend bit per cycle while shift is set, MSB first.
`default_nettype none

module rdcb_mod (
  input  wire logic                          clk,
  input  wire rdcb_pkg::mod_ctl_t            ctl,
  input  wire logic [rdcb_pkg::DIV_W-1:0]    dividend,
  input  wire logic [rdcb_pkg::PERIOD_W-1:0] period10,
  output logic      [rdcb_pkg::PERIOD_W-1:0] rem
);
  import rdcb_pkg::*;

  logic [DIV_W-1:0]    div_sr_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [PERIOD_W-1:0] rem_nxt;
  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W:0]   per_ext;
  logic [PERIOD_W:0]   diff;

  // Shift in next bit, subtract period when it fits
  always_comb begin
    trial   = {rem_r, div_sr_r[DIV_W-1]};
    per_ext = {1'b0, period10};
    diff    = trial - per_ext;
    if (trial >= per_ext) begin
      rem_nxt = diff[PERIOD_W-1:0];
    end else begin
      rem_nxt = trial[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      div_sr_r <= dividend;
      rem_r    <= '0;
    end else if (ctl.shift) begin
      div_sr_r <= {div_sr_r[DIV_W-2:0], 1'b0};
      rem_r    <= rem_nxt;
    end
  end

  assign rem = rem_r;

endmodule

`default_nettype wire

>>> src/rotating_display_color_bands_top.sv
// Top level of the rotating display color band generator.
`default_nettype none

// Color band generator for a spinning LED display. Each input transaction is a
// tachometer pulse (in_tuser = 1) or a pixel tick (in_tuser = 0). A tach pulse
// produces no result and is absorbed in the idle state. A pixel tick produces
// one result transaction with the red, green and blue compare values; it holds
// the block through the load, divide and output states. In the divide state
// three bit-serial remainder units retire one dividend bit per cycle, forming
// (10 * counter + offset) mod (10 * pixels_per_rev). The output register holds
// a finished result while the next transaction is taken. Configuration must be
// written through the APB port while the block is idle; it is not enforced.
module rotating_display_color_bands_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // [0] motor_running
  input  wire logic [0:0]                       in_tuser,   // [0] req_type
  // Result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [23:0]                      out_tdata,  // [7:0] red_width,
                                                            // [15:8] green_width,
                                                            // [23:16] blue_width
  // Configuration
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [rdcb_pkg::ADDR_W-1:0]      cfg_paddr,
  input  wire logic [rdcb_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic      [rdcb_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                                  cfg_pready
);
  import rdcb_pkg::*;

  cfg_t                cfg;
  mod_ctl_t            mod_ctl;

  rdcb_state_t         state_r;
  rdcb_state_t         state_nxt;
  logic [CNT_W-1:0]    bit_cnt_r;
  logic [CNT_W-1:0]    bit_cnt_nxt;

  logic [COUNT_BITS-1:0] counter_r;
  logic [COUNT_BITS-1:0] counter_nxt;
  logic [DIVIDE_W-1:0] tach_cnt_r;
  logic [DIVIDE_W-1:0] tach_cnt_nxt;
  logic [DIVIDE_W-1:0] tach_inc;
  logic [OFF_W-1:0]    red_off_r;
  logic [OFF_W-1:0]    red_off_nxt;
  logic [OFF_W-1:0]    green_off_r;
  logic [OFF_W-1:0]    green_off_nxt;
  logic [OFF_W-1:0]    blue_off_r;
  logic [OFF_W-1:0]    blue_off_nxt;
  logic                run_r;
  logic                run_nxt;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [23:0]         out_data_r;
  logic [23:0]         out_data_nxt;
  logic                out_load;

  logic                in_acc;
  logic [PERIOD_W-1:0] period10;
  logic [DIV_W-1:0]    cnt10;
  logic [DIV_W-1:0]    div_red;
  logic [DIV_W-1:0]    div_green;
  logic [DIV_W-1:0]    div_blue;
  logic [PERIOD_W-1:0] pos_red;
  logic [PERIOD_W-1:0] pos_green;
  logic [PERIOD_W-1:0] pos_blue;

  logic [BAND_W-1:0]   p_b;
  logic [BAND_W-1:0]   p3;
  logic [BAND_W-1:0]   p5;
  logic [BAND_W-1:0]   p6;
  logic [BAND_W-1:0]   p9;
  logic                active;
  logic                red_on;
  logic                green_on;
  logic                blue_on;

  // Offset advance; wraps to zero at the period
  function automatic logic [OFF_W-1:0] adv_off(input logic [OFF_W-1:0]    off,
                                               input logic [STEP_W-1:0]   step,
                                               input logic [PERIOD_W-1:0] per);
    logic [PERIOD_W-1:0] sum;
    sum = PERIOD_W'(off) + PERIOD_W'(step);
    if (sum >= per) begin
      return '0;
    end
    return sum[OFF_W-1:0];
  endfunction

  rdcb_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign period10 = PERIOD_W'(cfg.pixels_per_rev) * PERIOD_W'(10);

  // Dividends, formed in the load state from the updated counter
  assign cnt10     = DIV_W'(counter_r) * DIV_W'(10);
  assign div_red   = cnt10 + DIV_W'(red_off_r);
  assign div_green = cnt10 + DIV_W'(green_off_r);
  assign div_blue  = cnt10 + DIV_W'(blue_off_r);

  rdcb_mod u_mod_red (
    .clk      (clk),
    .ctl      (mod_ctl),
    .dividend (div_red),
    .period10 (period10),
    .rem      (pos_red)
  );

  rdcb_mod u_mod_green (
    .clk      (clk),
    .ctl      (mod_ctl),
    .dividend (div_green),
    .period10 (period10),
    .rem      (pos_green)
  );

  rdcb_mod u_mod_blue (
    .clk      (clk),
    .ctl      (mod_ctl),
    .dividend (div_blue),
    .period10 (period10),
    .rem      (pos_blue)
  );

  assign in_acc = in_tvalid & in_tready;

  // Next state
  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser[0] == REQ_PIXEL)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt   = ST_DIV;
        bit_cnt_nxt = '0;
      end
      ST_DIV: begin
        bit_cnt_nxt = bit_cnt_r + CNT_W'(1);
        if (bit_cnt_r == CNT_W'(DIV_W - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready     = 1'b0;
    mod_ctl.load  = 1'b0;
    mod_ctl.shift = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: in_tready     = 1'b1;
      ST_LOAD: mod_ctl.load  = 1'b1;
      ST_DIV:  mod_ctl.shift = 1'b1;
      ST_OUT:  out_load      = !out_valid_r || out_tready;
      default: in_tready     = 1'b0;
    endcase
  end

  // Counter, tach divider and offsets
  assign tach_inc = tach_cnt_r + DIVIDE_W'(1);

  always_comb begin
    counter_nxt   = counter_r;
    tach_cnt_nxt  = tach_cnt_r;
    red_off_nxt   = red_off_r;
    green_off_nxt = green_off_r;
    blue_off_nxt  = blue_off_r;
    run_nxt       = run_r;
    if (in_acc) begin
      if (in_tuser[0] == REQ_TACH) begin
        if (tach_inc < cfg.tach_divide) begin
          tach_cnt_nxt = tach_inc;
        end else begin
          tach_cnt_nxt  = '0;
          counter_nxt   = '0;
          red_off_nxt   = adv_off(red_off_r, cfg.red_step, period10);
          green_off_nxt = adv_off(green_off_r, cfg.green_step, period10);
          blue_off_nxt  = adv_off(blue_off_r, cfg.blue_step, period10);
        end
      end else begin
        run_nxt = in_tdata[0];
        if (counter_r != '1) begin
          counter_nxt = counter_r + COUNT_BITS'(1);
        end
      end
    end
  end

  // Band decode on the finished positions
  always_comb begin
    p_b      = BAND_W'(cfg.pixels_per_rev);
    p3       = p_b * BAND_W'(3);
    p5       = p_b * BAND_W'(5);
    p6       = p_b * BAND_W'(6);
    p9       = p_b * BAND_W'(9);
    active   = run_r && (cfg.pixels_per_rev != '0);
    red_on   = BAND_W'(pos_red) < p3;
    green_on = ({pos_green, 1'b0} >= p5) && (BAND_W'(pos_green) < p6);
    blue_on  = (BAND_W'(pos_blue) >= p5) && (BAND_W'(pos_blue) < p9);
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      if (active && red_on) begin
        out_data_nxt[7:0] = cfg.on_level;
      end
      if (active && green_on) begin
        out_data_nxt[15:8] = cfg.on_level;
      end
      if (active && blue_on) begin
        out_data_nxt[23:16] = cfg.on_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      counter_r   <= '0;
      tach_cnt_r  <= '0;
      red_off_r   <= '0;
      green_off_r <= '0;
      blue_off_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      counter_r   <= counter_nxt;
      tach_cnt_r  <= tach_cnt_nxt;
      red_off_r   <= red_off_nxt;
      green_off_r <= green_off_nxt;
      blue_off_r  <= blue_off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    bit_cnt_r  <= bit_cnt_nxt;
    run_r      <= run_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A new result only appears out of the output state
  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result appeared outside the output state");

  // A stopped motor gives a dark pixel
  a_dark_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !run_r) |=> (out_tdata == '0))
    else $error("nonzero result while motor stopped");

  // A tach pulse never starts the remainder sequence
  a_tach_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser[0] == REQ_TACH)) |=> (state_r == ST_IDLE))
    else $error("tach pulse left the idle state");

  // Bit counter never runs past the dividend
  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (bit_cnt_r <= CNT_W'(DIV_W - 1)))
    else $error("bit counter out of range");

endmodule

`default_nettype wire

>>> verif/tb_rotating_display_color_bands_top.sv
// Self-checking testbench for the rotating display color band generator.
module tb_rotating_display_color_bands_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rdcb_pkg::*;

  localparam int SETTLE_CYCLES = 40;    // covers the time a pixel tick keeps the block busy
  localparam int LONG_HOLD     = 400;   // receiver hold-off that backs the block up
  localparam int STUCK_LIMIT   = 2000;  // cycles without any transaction
  localparam int TAIL_TICKS    = 40;    // pixel ticks before the final counted revolution

  // One input transaction: tuser carries the kind, tdata[0] the motor state
  typedef struct packed {
    logic req;
    logic running;
  } band_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [0] motor_running
  logic [0:0]  in_tuser = '0;   // [0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [7:0] red, [15:8] green, [23:16] blue

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]     cfg_paddr = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Stimulus backlog and the band values still owed by the block
  band_req_t   req_backlog[$];
  logic [23:0] band_due[$];

  // Shadow registers
  logic [PPR_W-1:0]    sh_ppr = RST_PIXELS_PER_REV;
  logic [LEVEL_W-1:0]  sh_level = RST_ON_LEVEL;
  logic [DIVIDE_W-1:0] sh_divide = RST_TACH_DIVIDE;
  logic [STEP_W-1:0]   sh_red_step = RST_RED_STEP;
  logic [STEP_W-1:0]   sh_green_step = RST_GREEN_STEP;
  logic [STEP_W-1:0]   sh_blue_step = RST_BLUE_STEP;

  // Shadow rotation state
  logic [COUNT_BITS-1:0] pix_count = '0;
  logic [3:0]            tach_count = '0;
  logic [OFF_W-1:0]      red_off = '0;
  logic [OFF_W-1:0]      green_off = '0;
  logic [OFF_W-1:0]      blue_off = '0;

  logic quiet = 1'b0;     // no random idling on either side while set
  int   err_cnt = 0;
  int   results_seen = 0;
  int   send_wait = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   stuck = 0;

  rotating_display_color_bands_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic void note_err(string what, logic [31:0] exp_v, logic [31:0] got_v);
    if (err_cnt < 10) begin
      $display("mismatch on %s: expected %0h, got %0h", what, exp_v, got_v);
    end
    err_cnt++;
  endfunction

  function automatic int draw_wait();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Offset advance; wraps to zero at the period, else truncates to 16 bits
  function automatic logic [OFF_W-1:0] step_offset(logic [OFF_W-1:0] off,
                                                   logic [STEP_W-1:0] step,
                                                   logic [31:0] period10);
    logic [31:0] sum;
    sum = 32'(off) + 32'(step);
    if (sum >= period10) return '0;
    return sum[OFF_W-1:0];
  endfunction

  // Updates the shadow state for one accepted transaction; pixel ticks owe a result
  function automatic void predict_bands(band_req_t item);
    logic [31:0] period10;
    logic [63:0] p, pos_r, pos_g, pos_b;
    logic [7:0]  r, g, b;
    period10 = 32'(sh_ppr) * 32'd10;
    if (item.req == REQ_TACH) begin
      tach_count = tach_count + 4'd1;
      // a divider of zero counts every pulse
      if (tach_count >= sh_divide) begin
        tach_count = '0;
        pix_count  = '0;
        red_off    = step_offset(red_off, sh_red_step, period10);
        green_off  = step_offset(green_off, sh_green_step, period10);
        blue_off   = step_offset(blue_off, sh_blue_step, period10);
      end
    end else begin
      if (pix_count != '1) pix_count = pix_count + 1'b1;
      r = '0;
      g = '0;
      b = '0;
      // positions in tenths of a pixel, exact integer compares against the bands
      if (item.running && sh_ppr != '0) begin
        p     = 64'(sh_ppr);
        pos_r = (64'(pix_count) * 64'd10 + 64'(red_off)) % 64'(period10);
        pos_g = (64'(pix_count) * 64'd10 + 64'(green_off)) % 64'(period10);
        pos_b = (64'(pix_count) * 64'd10 + 64'(blue_off)) % 64'(period10);
        if (pos_r < 64'd3 * p) r = sh_level;
        if (64'd2 * pos_g >= 64'd5 * p && pos_g < 64'd6 * p) g = sh_level;
        if (pos_b >= 64'd5 * p && pos_b < 64'd9 * p) b = sh_level;
      end
      band_due.push_back({b, g, r});
    end
  endfunction

  // Driver: presents backlog items, predicts on every accepted transaction
  always @(posedge clk) begin
    band_req_t item;
    int        nxt;
    logic      load;
    load = 1'b0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        item.req     = in_tuser[0];
        item.running = in_tdata[0];
        predict_bands(item);
        nxt = draw_wait();
        if (nxt == 0) load = 1'b1;
        else send_wait <= nxt;
      end else if (!in_tvalid) begin
        if (send_wait != 0) send_wait <= send_wait - 1;
        else load = 1'b1;
      end
      if (load && req_backlog.size() != 0) begin
        item = req_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= item.req;
        in_tdata  <= {7'b0, item.running};
      end else if (in_tvalid && in_tready) begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs at two points of the run
  always @(posedge clk) begin
    int s;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= (hold_left == 1);
    end else if (out_tvalid && out_tready) begin
      if (results_seen == 150 || results_seen == 450) begin
        hold_left  <= LONG_HOLD;
        out_tready <= 1'b0;
      end else begin
        s = draw_wait();
        stall_left <= s;
        out_tready <= (s == 0);
      end
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: each result transaction against the oldest owed band values
  always @(posedge clk) begin
    logic [23:0] want;
    string       chan [3];
    chan = '{"red_width", "green_width", "blue_width"};
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (band_due.size() == 0) begin
        note_err("result with nothing pending", '0, 32'(out_tdata));
      end else begin
        want = band_due.pop_front();
        for (int c = 0; c < 3; c++) begin
          if (out_tdata[8*c +: 8] !== want[8*c +: 8]) begin
            note_err(chan[c], 32'(want[8*c +: 8]), 32'(out_tdata[8*c +: 8]));
          end
        end
      end
    end
  end

  // Watchdog: no transaction on either stream for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck <= 0;
    end else if (stuck == STUCK_LIMIT) begin
      $display("[rotating_display_color_bands_top] ERROR");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  task automatic reg_check(input logic [IDX_W-1:0] idx, input logic [31:0] want);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) note_err($sformatf("register %0d", idx), want, cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // APB write with junk above the field, shadow update, then read-back
  task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [31:0] val,
                           input int width);
    logic [31:0] field;
    field = val & ((32'd1 << width) - 32'd1);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= field | ($urandom << width);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_PIXELS_PER_REV: sh_ppr = field[PPR_W-1:0];
      REG_ON_LEVEL:       sh_level = field[LEVEL_W-1:0];
      REG_TACH_DIVIDE:    sh_divide = field[DIVIDE_W-1:0];
      REG_RED_STEP:       sh_red_step = field[STEP_W-1:0];
      REG_GREEN_STEP:     sh_green_step = field[STEP_W-1:0];
      REG_BLUE_STEP:      sh_blue_step = field[STEP_W-1:0];
      default: ;
    endcase
    reg_check(idx, field);
  endtask

  // Wait until everything sent has come back, then let the block drain
  task automatic settle();
    while (req_backlog.size() != 0 || in_tvalid || band_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_bands(input int ppr, input int level, input int divide,
                           input int rs, input int gs, input int bs);
    settle();
    reg_write(REG_PIXELS_PER_REV, ppr, PPR_W);
    reg_write(REG_ON_LEVEL, level, LEVEL_W);
    reg_write(REG_TACH_DIVIDE, divide, DIVIDE_W);
    reg_write(REG_RED_STEP, rs, STEP_W);
    reg_write(REG_GREEN_STEP, gs, STEP_W);
    reg_write(REG_BLUE_STEP, bs, STEP_W);
  endtask

  task automatic push_req(input logic req, input logic running, input int n);
    repeat (n) req_backlog.push_back({req, running});
  endtask

  task automatic push_random(input int n, input int tach_pct, input int run_pct);
    repeat (n) begin
      req_backlog.push_back({($urandom_range(0, 99) < tach_pct) ? REQ_TACH : REQ_PIXEL,
                             1'($urandom_range(0, 99) < run_pct)});
    end
  endtask

  function automatic int pick_byte();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int pick_period();
    case ($urandom_range(0, 9))
      0:       return 1;
      1, 2, 3: return $urandom_range(1, 20);
      4:       return 8191;
      5:       return 0;
      6:       return $urandom_range(0, 8191);
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  // Main sequence
  initial begin
    int tach_pct;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset values of the register file
    reg_check(REG_PIXELS_PER_REV, 32'(RST_PIXELS_PER_REV));
    reg_check(REG_ON_LEVEL, 32'(RST_ON_LEVEL));
    reg_check(REG_TACH_DIVIDE, 32'(RST_TACH_DIVIDE));
    reg_check(REG_RED_STEP, 32'(RST_RED_STEP));
    reg_check(REG_GREEN_STEP, 32'(RST_GREEN_STEP));
    reg_check(REG_BLUE_STEP, 32'(RST_BLUE_STEP));

    // directed: defaults, motor stopped, one counted revolution
    push_req(REQ_PIXEL, 1'b1, 3);
    push_req(REQ_PIXEL, 1'b0, 1);
    push_req(REQ_TACH, 1'b1, 6);
    push_req(REQ_PIXEL, 1'b1, 2);

    // directed: shortest period, full level, divider of zero, largest steps
    set_bands(1, 255, 0, 255, 255, 255);
    push_req(REQ_TACH, 1'b0, 2);
    push_req(REQ_PIXEL, 1'b1, 3);
    push_req(REQ_PIXEL, 1'b0, 1);

    // directed: zero period
    set_bands(0, 255, 1, 7, 7, 7);
    push_req(REQ_PIXEL, 1'b1, 2);
    push_req(REQ_TACH, 1'b1, 2);
    push_req(REQ_PIXEL, 1'b1, 1);

    // random settings, mixes of tach pulses and pixel ticks
    for (int ph = 0; ph < 8; ph++) begin
      set_bands(pick_period(), pick_byte(), $urandom_range(0, 15),
                pick_byte(), pick_byte(), pick_byte());
      quiet <= (ph == 3);
      case ($urandom_range(0, 2))
        0:       tach_pct = 5;
        1:       tach_pct = 20;
        default: tach_pct = 50;
      endcase
      push_random(100, tach_pct, 85);
    end

    // period over 6553 pixels: offsets climb past 16 bits and wrap
    set_bands(8191, pick_byte(), 1, 255, 250, 245);
    quiet <= 1'b0;
    push_random(350, 80, 85);

    // back-to-back run of pixel ticks, then a counted revolution
    set_bands(1000, 255, 15, 3, 5, 7);
    quiet <= 1'b1;
    push_random(TAIL_TICKS, 0, 90);
    push_req(REQ_TACH, 1'b1, 15);
    push_req(REQ_PIXEL, 1'b1, 3);

    settle();
    if (err_cnt == 0) begin
      $display("[rotating_display_color_bands_top] OK");
    end else begin
      $display("[rotating_display_color_bands_top] ERROR");
    end
    $finish;
  end

endmodule
